FILE: hdl/blld_pkg.sv
// ----------------------------------------------------------------------------
// blld_pkg: shared definitions for the bounded list deque
// Operation and status codes, sequencer phases and the control word that the
// sequencer hands to every storage cell.
// ----------------------------------------------------------------------------
package blld_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // operation kinds
   localparam logic [KIND_W-1:0] OP_PUSH_FRONT   = 3'd0;
   localparam logic [KIND_W-1:0] OP_PUSH_BACK    = 3'd1;
   localparam logic [KIND_W-1:0] OP_REMOVE_VALUE = 3'd2;
   localparam logic [KIND_W-1:0] OP_REMOVE_BACK  = 3'd3;
   localparam logic [KIND_W-1:0] OP_REMOVE_FRONT = 3'd4;
   localparam logic [KIND_W-1:0] OP_SEARCH       = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // sequencer phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CMP  = 2'd1;
   localparam logic [1:0] PH_EXE  = 2'd2;

   // per-cycle command broadcast to all cells
   typedef struct packed {
      logic capture;    // register the key compare
      logic shr;        // take the left neighbor (insert at head)
      logic shl_all;    // take the right neighbor (drop head)
      logic shl_match;  // take the right neighbor at and after the first hit
      logic load_tail;  // the cell at the current count takes the key
   } cell_ctrl_type;

endpackage

FILE: hdl/blld_cell.sv
// ----------------------------------------------------------------------------
// blld_cell: one storage cell of the list
// Holds one entry, compares it with the key and moves data to or from its
// neighbors as the broadcast command says.
// ----------------------------------------------------------------------------
module blld_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                           clock,
   input  blld_pkg::cell_ctrl_type        ctrl,
   input  logic [blld_pkg::VALUE_W-1:0]   key,
   input  logic [CNT_W-1:0]               count,
   input  logic [blld_pkg::VALUE_W-1:0]   left_value,
   input  logic [blld_pkg::VALUE_W-1:0]   right_value,
   input  logic                           hit_in,
   output logic                           hit_out,
   output logic [blld_pkg::VALUE_W-1:0]   value
);

   logic [blld_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                         eq_ff, eq_in;
   logic                         occupied;
   logic                         at_tail;

   assign occupied = count > CNT_W'(INDEX);
   assign at_tail  = count == CNT_W'(INDEX);
   assign eq_in    = occupied && (value_ff == key);

   // at or after the first matching entry from the head
   assign hit_out = hit_in | eq_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shr) begin
         value_in = left_value;
      end else if (ctrl.shl_all || (ctrl.shl_match && hit_out)) begin
         value_in = right_value;
      end else if (ctrl.load_tail && at_tail) begin
         value_in = key;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (ctrl.capture) begin
         eq_ff <= eq_in;
      end
   end

   assign value = value_ff;

endmodule

FILE: hdl/blld_chain.sv
// ----------------------------------------------------------------------------
// blld_chain: row of storage cells
// Links the cells head to tail: value neighbors for shifting and the hit
// chain that marks the first match.
// ----------------------------------------------------------------------------
module blld_chain #(
   parameter int CAPACITY = blld_pkg::DEFAULT_CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                           clock,
   input  blld_pkg::cell_ctrl_type        ctrl,
   input  logic [blld_pkg::VALUE_W-1:0]   key,
   input  logic [CNT_W-1:0]               count,
   output logic                           found
);

   logic [blld_pkg::VALUE_W-1:0] value_w [CAPACITY];
   logic [CAPACITY:0]            hit_w;

   assign hit_w[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [blld_pkg::VALUE_W-1:0] left_w, right_w;

      if (i == 0) begin : g_head
         assign left_w = key;
      end else begin : g_left
         assign left_w = value_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_w = value_w[i];
      end else begin : g_right
         assign right_w = value_w[i+1];
      end

      blld_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .key         (key),
         .count       (count),
         .left_value  (left_w),
         .right_value (right_w),
         .hit_in      (hit_w[i]),
         .hit_out     (hit_w[i+1]),
         .value       (value_w[i])
      );
   end

   assign found = hit_w[CAPACITY];

endmodule

FILE: hdl/bounded_list_deque_unit.sv
// ----------------------------------------------------------------------------
// bounded_list_deque_unit: bounded list with deque and delete-by-value
// Ordered list of up to CAPACITY signed 32-bit entries, head at the front.
// ----------------------------------------------------------------------------
// Each request beat carries an operation (push front, push back, remove first
// matching value, remove back, remove front, search) and returns one response
// beat with status, found flag and the entry count after the operation. An
// operation runs in order: the beat is taken, every cell compares its
// entry with the key in parallel, then the cells shift or load in one step and
// the response is registered. A new request is taken in the cycle after that,
// so a request is not taken until the one before it has finished its compare
// and execute steps in the cell row; a waiting response does not block the next
// request, but the execute step holds until the response register is free.
// ----------------------------------------------------------------------------
module bounded_list_deque_unit #(
   parameter int CAPACITY = blld_pkg::DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic [7:0]  req_tuser,   // [2:0] kind, [7:3] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] status, [2] found, [7:3] entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [1:0]                     phase_ff, phase_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [blld_pkg::KIND_W-1:0]    kind_ff;
   logic [blld_pkg::VALUE_W-1:0]   key_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [blld_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                           found_ff, found_in;
   logic [blld_pkg::COUNT_W-1:0]   rcount_ff, rcount_in;

   blld_pkg::cell_ctrl_type        ctrl;
   logic                           chain_found;
   logic                           req_fire;
   logic                           exe_go;
   logic                           full;
   logic                           empty;
   logic [CNT_W+blld_pkg::COUNT_W-1:0] count_wide;

   assign req_tready = phase_ff == blld_pkg::PH_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign exe_go     = (phase_ff == blld_pkg::PH_EXE) && (!rsp_valid_ff || rsp_tready);
   assign full       = count_ff == CNT_W'(CAPACITY);
   assign empty      = count_ff == '0;

   blld_chain #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .key   (key_ff),
      .count (count_ff),
      .found (chain_found)
   );

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = blld_pkg::ST_OK;
      found_in     = 1'b0;
      ctrl         = '0;
      ctrl.capture = phase_ff == blld_pkg::PH_CMP;

      case (phase_ff)
         blld_pkg::PH_IDLE: begin
            if (req_fire) begin
               phase_in = blld_pkg::PH_CMP;
            end
         end
         blld_pkg::PH_CMP: begin
            phase_in = blld_pkg::PH_EXE;
         end
         blld_pkg::PH_EXE: begin
            if (exe_go) begin
               phase_in     = blld_pkg::PH_IDLE;
               rsp_valid_in = 1'b1;
               case (kind_ff)
                  blld_pkg::OP_PUSH_FRONT: begin
                     if (full) begin
                        status_in = blld_pkg::ST_FULL;
                     end else begin
                        ctrl.shr = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  blld_pkg::OP_PUSH_BACK: begin
                     if (full) begin
                        status_in = blld_pkg::ST_FULL;
                     end else begin
                        ctrl.load_tail = 1'b1;
                        count_in       = count_ff + 1'b1;
                     end
                  end
                  blld_pkg::OP_REMOVE_VALUE: begin
                     if (empty) begin
                        status_in = blld_pkg::ST_EMPTY;
                     end else if (chain_found) begin
                        ctrl.shl_match = 1'b1;
                        found_in       = 1'b1;
                        count_in       = count_ff - 1'b1;
                     end else begin
                        status_in = blld_pkg::ST_NOTFOUND;
                     end
                  end
                  blld_pkg::OP_REMOVE_BACK: begin
                     if (empty) begin
                        status_in = blld_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  blld_pkg::OP_REMOVE_FRONT: begin
                     if (empty) begin
                        status_in = blld_pkg::ST_EMPTY;
                     end else begin
                        ctrl.shl_all = 1'b1;
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  blld_pkg::OP_SEARCH: begin
                     if (chain_found) begin
                        found_in = 1'b1;
                     end else begin
                        status_in = blld_pkg::ST_NOTFOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            phase_in = blld_pkg::PH_IDLE;
         end
      endcase
   end

   // report the count masked to the field width
   assign count_wide = {{blld_pkg::COUNT_W{1'b0}}, count_in};
   assign rcount_in  = count_wide[blld_pkg::COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= blld_pkg::PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_tuser[blld_pkg::KIND_W-1:0];
         key_ff  <= req_tdata;
      end
      if (exe_go) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         rcount_ff <= rcount_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rcount_ff, found_ff, status_ff};

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (phase_ff == blld_pkg::PH_CMP) && !req_tready)
      else $error("request beat did not start the compare step");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == blld_pkg::ST_FULL) |-> full)
      else $error("full status while list not full");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && found_ff |-> status_ff == blld_pkg::ST_OK)
      else $error("found flag with error status");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bounded_list_deque_unit
// Drives push, remove and search beats and keeps its own copy of the list.
// Every response beat is compared field by field with the predicted one.
// Random idle bursts are inserted on both the request and response sides.
// ----------------------------------------------------------------------------
module tb;

   localparam int CAPACITY    = blld_pkg::DEFAULT_CAPACITY;
   localparam int KIND_W      = blld_pkg::KIND_W;
   localparam int VALUE_W     = blld_pkg::VALUE_W;
   localparam int STATUS_W    = blld_pkg::STATUS_W;
   localparam int COUNT_W     = blld_pkg::COUNT_W;
   localparam int N_RANDOM    = 620;
   localparam int CYCLE_LIMIT = 200000;

   // kinds six and seven do nothing
   localparam logic [KIND_W-1:0] KIND_NOP6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_NOP7 = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [COUNT_W-1:0]  count;
   } op_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] item_value
   logic [7:0]  req_tuser;    // [2:0] kind, [7:3] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [1:0] status, [2] found, [7:3] entry_count

   logic [VALUE_W-1:0] list_q[$];       // predicted list contents, head first
   op_result_type      expected_rsp[$]; // responses still owed by the block
   op_result_type      exp_beat;

   bit idle_on;
   int stall_left;
   int err_count;
   int cycle_count;
   int n_sent;
   int n_checked;
   int n_full_hits;
   int n_empty_hits;

   bounded_list_deque_unit #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Apply one operation to the list copy and return the response it owes.
   function automatic op_result_type apply_op(input logic [KIND_W-1:0] kind,
                                              input logic [VALUE_W-1:0] value);
      op_result_type r;
      int            pos;
      int            i;
      r.status = blld_pkg::ST_OK;
      r.found  = 1'b0;
      pos      = -1;
      case (kind)
         blld_pkg::OP_PUSH_FRONT: begin
            if (list_q.size() >= CAPACITY) r.status = blld_pkg::ST_FULL;
            else list_q.push_front(value);
         end
         blld_pkg::OP_PUSH_BACK: begin
            if (list_q.size() >= CAPACITY) r.status = blld_pkg::ST_FULL;
            else list_q.push_back(value);
         end
         blld_pkg::OP_REMOVE_VALUE: begin
            if (list_q.size() == 0) begin
               r.status = blld_pkg::ST_EMPTY;
            end else begin
               for (i = 0; i < list_q.size() && pos < 0; i++)
                  if (list_q[i] == value) pos = i;
               if (pos >= 0) begin
                  list_q.delete(pos);
                  r.found = 1'b1;
               end else begin
                  r.status = blld_pkg::ST_NOTFOUND;
               end
            end
         end
         blld_pkg::OP_REMOVE_BACK: begin
            if (list_q.size() == 0) r.status = blld_pkg::ST_EMPTY;
            else void'(list_q.pop_back());
         end
         blld_pkg::OP_REMOVE_FRONT: begin
            if (list_q.size() == 0) r.status = blld_pkg::ST_EMPTY;
            else void'(list_q.pop_front());
         end
         blld_pkg::OP_SEARCH: begin
            for (i = 0; i < list_q.size() && pos < 0; i++)
               if (list_q[i] == value) pos = i;
            if (pos >= 0) r.found = 1'b1;
            else r.status = blld_pkg::ST_NOTFOUND;
         end
         default: ;
      endcase
      r.count = COUNT_W'(list_q.size());
      return r;
   endfunction

   // Favor values already held so that searches and removals hit often.
   function automatic logic [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel < 4 && list_q.size() > 0)
         return list_q[$urandom_range(0, list_q.size() - 1)];
      else if (sel < 6)
         return VALUE_W'($urandom_range(0, 8)) - 32'd4;
      else
         return $urandom();
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(input bit grow);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)  return roll[0] ? KIND_NOP6 : KIND_NOP7;
      if (roll < 15) return blld_pkg::OP_SEARCH;
      if (roll < 28) return blld_pkg::OP_REMOVE_VALUE;
      if (grow) begin
         if (roll < 64) return blld_pkg::OP_PUSH_FRONT;
         if (roll < 90) return blld_pkg::OP_PUSH_BACK;
         if (roll < 95) return blld_pkg::OP_REMOVE_BACK;
         return blld_pkg::OP_REMOVE_FRONT;
      end
      if (roll < 50) return blld_pkg::OP_REMOVE_BACK;
      if (roll < 72) return blld_pkg::OP_REMOVE_FRONT;
      if (roll < 86) return blld_pkg::OP_PUSH_FRONT;
      return blld_pkg::OP_PUSH_BACK;
   endfunction

   // Send one request beat; the prediction is made when the beat is taken.
   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
      op_result_type r;
      int            gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {5'd0, kind};
      do @(posedge clock); while (!req_tready);
      r = apply_op(kind, value);
      expected_rsp.push_back(r);
      n_sent++;
      if (r.status == blld_pkg::ST_FULL)  n_full_hits++;
      if (r.status == blld_pkg::ST_EMPTY) n_empty_hits++;
   endtask

   // Drop valid and hold until every owed response has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_list();
      send_op(blld_pkg::OP_REMOVE_FRONT, 32'd0);
      send_op(blld_pkg::OP_REMOVE_BACK, 32'hFFFF_FFFF);
      send_op(blld_pkg::OP_REMOVE_VALUE, 32'h8000_0000);
      send_op(blld_pkg::OP_SEARCH, 32'h7FFF_FFFF);
      send_op(KIND_NOP6, 32'h1234_5678);
      send_op(KIND_NOP7, 32'hEDCB_A987);
   endtask

   // Fill to capacity from both ends with extremes and duplicates, then overflow.
   task automatic test_fill_to_overflow();
      logic [VALUE_W-1:0] fill_vals[16];
      int i;
      fill_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0,
                    32'd5, 32'hAAAA_AAAA, 32'h5555_5555, 32'd5,
                    32'd1, 32'hFFFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFE,
                    32'd5, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'd2};
      for (i = 0; i < CAPACITY; i++)
         send_op(i[0] ? blld_pkg::OP_PUSH_FRONT : blld_pkg::OP_PUSH_BACK,
                 fill_vals[i % 16]);
      send_op(blld_pkg::OP_PUSH_FRONT, 32'd99);
      send_op(blld_pkg::OP_PUSH_BACK, 32'd98);
   endtask

   task automatic test_match_and_miss();
      send_op(blld_pkg::OP_SEARCH, 32'h8000_0000);
      send_op(blld_pkg::OP_REMOVE_VALUE, 32'd5);      // first of several copies goes
      send_op(blld_pkg::OP_REMOVE_VALUE, 32'd12345);
   endtask

   // Drift between growing and shrinking so that full and empty recur.
   task automatic test_random_mix();
      bit grow;
      int i;
      grow = 1'b1;
      for (i = 0; i < N_RANDOM; i++) begin
         if (i % 150 == 149) wait_for_drain();
         if (i == N_RANDOM - 100) idle_on = 1'b0;
         if (list_q.size() == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
         if (list_q.size() == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
         send_op(pick_kind(grow), pick_value());
      end
   endtask

   // Response side: random stall bursts while idling is enabled.
   always @(negedge clock) begin
      if (idle_on && stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: response beat with nothing expected, actual %h", $time, rsp_tdata);
            err_count++;
         end else begin
            exp_beat = expected_rsp.pop_front();
            n_checked++;
            if (rsp_tdata[1:0] !== exp_beat.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, exp_beat.status, rsp_tdata[1:0]);
               err_count++;
            end
            if (rsp_tdata[2] !== exp_beat.found) begin
               $display("%0t: found mismatch, expected %0d actual %0d",
                        $time, exp_beat.found, rsp_tdata[2]);
               err_count++;
            end
            if (rsp_tdata[7:3] !== exp_beat.count) begin
               $display("%0t: entry_count mismatch, expected %0d actual %0d",
                        $time, exp_beat.count, rsp_tdata[7:3]);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, expected_rsp.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      idle_on    = 1'b1;
      stall_left = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_fill_to_overflow();
      test_match_and_miss();
      test_random_mix();

      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("tb: %0d beats sent, %0d responses checked, all eight kinds used",
               n_sent, n_checked);
      $display("tb: %0d pushes hit a full list, %0d operations hit an empty list",
               n_full_hits, n_empty_hits);
      if (err_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
